// ===== sv/dsd_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package dsd_pkg;

   localparam int YearW   = 14;
   localparam int MonthW  = 4;
   localparam int DayW    = 5;
   localparam int CountW  = 16;
   localparam int StatusW = 2;

   localparam logic [YearW-1:0]   YearMax   = YearW'(9999);
   localparam logic [YearW-1:0]   YearCycle = YearW'(400);
   localparam logic [MonthW-1:0]  MonthJan  = MonthW'(1);
   localparam logic [MonthW-1:0]  MonthFeb  = MonthW'(2);
   localparam logic [MonthW-1:0]  MonthDec  = MonthW'(12);

   // Result status codes.
   localparam logic [StatusW-1:0] StatusOk       = 2'd0;
   localparam logic [StatusW-1:0] StatusBadDate  = 2'd1;
   localparam logic [StatusW-1:0] StatusBadRange = 2'd2;

   // Controller states, one-hot.
   typedef enum logic [4:0] {
      ST_IDLE   = 5'b00001,
      ST_REDUCE = 5'b00010,
      ST_WALK   = 5'b00100,
      ST_DONE   = 5'b01000,
      ST_HOLD   = 5'b10000
   } state_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic load;
      logic reduce;
      logic step;
      logic finish;
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic reduce_more;
      logic invalid;
      logic walk_more;
      logic range_bad;
   } stat_type;

   // A year is a leap year from its remainder modulo 400.
   function automatic logic leap_of(input logic [YearW-1:0] yrem);
      leap_of = (yrem[1:0] == 2'b00) && (yrem != YearW'(100)) &&
                (yrem != YearW'(200)) && (yrem != YearW'(300));
   endfunction

   // Length of a month; months outside 1..12 read as 31.
   function automatic logic [DayW-1:0] month_len(input logic leap,
                                                 input logic [MonthW-1:0] month);
      logic [DayW-1:0] len;
      len = DayW'(31);
      case (month)
         MonthFeb: len = leap ? DayW'(29) : DayW'(28);
         4'd4:    len = DayW'(30);
         4'd6:    len = DayW'(30);
         4'd9:    len = DayW'(30);
         4'd11:   len = DayW'(30);
         default: len = DayW'(31);
      endcase
      month_len = len;
   endfunction

endpackage

`default_nettype wire

// ===== sv/dsd_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none

module dsd_ctrl (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_tvalid,
   output logic                   req_tready,
   output logic                   rsp_tvalid,
   input  wire logic              rsp_tready,
   input  wire dsd_pkg::stat_type stat,
   output dsd_pkg::cmd_type       cmd
);

   dsd_pkg::state_type state_ff, state_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic               out_free;

   // The output register can take a new result when empty or being drained.
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign req_tready = (state_ff == dsd_pkg::ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;

   // Next state and datapath commands.
   always_comb begin
      state_in   = state_ff;
      cmd        = '0;
      case (state_ff)
         dsd_pkg::ST_IDLE: begin
            if (req_tvalid) begin
               cmd.load = 1'b1;
               state_in = dsd_pkg::ST_REDUCE;
            end
         end
         dsd_pkg::ST_REDUCE: begin
            if (stat.reduce_more) begin
               cmd.reduce = 1'b1;
            end else begin
               state_in = dsd_pkg::ST_WALK;
            end
         end
         dsd_pkg::ST_WALK: begin
            if (stat.invalid || stat.range_bad || !stat.walk_more) begin
               state_in = dsd_pkg::ST_DONE;
            end else begin
               cmd.step = 1'b1;
            end
         end
         dsd_pkg::ST_DONE: begin
            if (out_free) begin
               cmd.finish = 1'b1;
               state_in   = dsd_pkg::ST_IDLE;
            end else begin
               state_in = dsd_pkg::ST_HOLD;
            end
         end
         dsd_pkg::ST_HOLD: begin
            if (out_free) begin
               cmd.finish = 1'b1;
               state_in   = dsd_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = dsd_pkg::ST_IDLE;
         end
      endcase
   end

   // The result valid flag is set when a result is written and cleared when taken.
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
      if (cmd.finish) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= dsd_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

`default_nettype wire

// ===== sv/dsd_datapath.sv =====
`timescale 1ns / 1ps
`default_nettype none

module dsd_datapath (
   input  wire logic                          clock,
   input  wire dsd_pkg::cmd_type              cmd,
   output dsd_pkg::stat_type                  stat,
   input  wire logic                          in_back,
   input  wire logic [dsd_pkg::YearW-1:0]     in_year,
   input  wire logic [dsd_pkg::MonthW-1:0]    in_month,
   input  wire logic [dsd_pkg::DayW-1:0]      in_day,
   input  wire logic [dsd_pkg::CountW-1:0]    in_count,
   output logic      [dsd_pkg::YearW-1:0]     res_year,
   output logic      [dsd_pkg::MonthW-1:0]    res_month,
   output logic      [dsd_pkg::DayW-1:0]      res_day,
   output logic      [dsd_pkg::StatusW-1:0]   res_status
);

   logic                          back_ff, back_in;
   logic [dsd_pkg::YearW-1:0]     year_ff, year_in;
   logic [dsd_pkg::YearW-1:0]     yrem_ff, yrem_in;
   logic [dsd_pkg::MonthW-1:0]    month_ff, month_in;
   logic [dsd_pkg::DayW-1:0]      day_ff, day_in;
   logic [dsd_pkg::CountW-1:0]    count_ff, count_in;
   logic                          bad_ff, bad_in;
   logic [dsd_pkg::YearW-1:0]     ryear_ff, ryear_in;
   logic [dsd_pkg::MonthW-1:0]    rmonth_ff, rmonth_in;
   logic [dsd_pkg::DayW-1:0]      rday_ff, rday_in;
   logic [dsd_pkg::StatusW-1:0]   rstat_ff, rstat_in;

   logic [dsd_pkg::DayW-1:0]      len_cur;
   logic [dsd_pkg::DayW-1:0]      room;
   logic [dsd_pkg::YearW-1:0]     yrem_prev;
   logic [dsd_pkg::MonthW-1:0]    month_prev;
   logic [dsd_pkg::YearW-1:0]     yrem_back;

   // Length of the current month and the days left in it after the current day.
   assign len_cur = dsd_pkg::month_len(dsd_pkg::leap_of(yrem_ff), month_ff);
   assign room    = len_cur - day_ff;

   // Status toward the controller.
   assign stat.reduce_more = (yrem_ff >= dsd_pkg::YearCycle);
   assign stat.invalid     = (year_ff > dsd_pkg::YearMax) || (month_ff == '0) ||
                             (month_ff > dsd_pkg::MonthDec) || (day_ff == '0) ||
                             (day_ff > len_cur);
   assign stat.walk_more   = back_ff ? (count_ff >= dsd_pkg::CountW'(day_ff))
                                     : (count_ff > dsd_pkg::CountW'(room));
   assign stat.range_bad   = bad_ff;

   // Year remainder and month after a backward step into the previous month.
   assign yrem_prev  = (yrem_ff == '0) ? (dsd_pkg::YearCycle - dsd_pkg::YearW'(1))
                                       : (yrem_ff - dsd_pkg::YearW'(1));
   assign month_prev = (month_ff <= dsd_pkg::MonthJan) ? dsd_pkg::MonthDec
                                                       : (month_ff - dsd_pkg::MonthW'(1));
   assign yrem_back  = (month_ff <= dsd_pkg::MonthJan) ? yrem_prev : yrem_ff;

   // Working registers: load, year reduction, and one month per step.
   always_comb begin
      back_in  = back_ff;
      year_in  = year_ff;
      yrem_in  = yrem_ff;
      month_in = month_ff;
      day_in   = day_ff;
      count_in = count_ff;
      bad_in   = bad_ff;
      if (cmd.load) begin
         back_in  = in_back;
         year_in  = in_year;
         yrem_in  = in_year;
         month_in = in_month;
         day_in   = in_day;
         count_in = in_count;
         bad_in   = 1'b0;
      end else if (cmd.reduce) begin
         yrem_in = yrem_ff - dsd_pkg::YearCycle;
      end else if (cmd.step) begin
         if (!back_ff) begin
            // Forward: consume the rest of this month and move to day 1 of the next.
            count_in = count_ff - dsd_pkg::CountW'(room) - dsd_pkg::CountW'(1);
            day_in   = dsd_pkg::DayW'(1);
            if (month_ff == dsd_pkg::MonthDec) begin
               month_in = dsd_pkg::MonthJan;
               year_in  = year_ff + dsd_pkg::YearW'(1);
               yrem_in  = (yrem_ff == dsd_pkg::YearCycle - dsd_pkg::YearW'(1)) ?
                          '0 : (yrem_ff + dsd_pkg::YearW'(1));
               if (year_ff >= dsd_pkg::YearMax) begin
                  bad_in = 1'b1;
               end
            end else begin
               month_in = month_ff + dsd_pkg::MonthW'(1);
            end
         end else begin
            // Backward: consume the days up to this one and land on the last of the prior month.
            count_in = count_ff - dsd_pkg::CountW'(day_ff);
            month_in = month_prev;
            yrem_in  = yrem_back;
            day_in   = dsd_pkg::month_len(dsd_pkg::leap_of(yrem_back), month_prev);
            if (month_ff <= dsd_pkg::MonthJan) begin
               if (year_ff == '0) begin
                  bad_in = 1'b1;
               end else begin
                  year_in = year_ff - dsd_pkg::YearW'(1);
               end
            end
         end
      end
   end

   // Result register, written once the walk has ended.
   always_comb begin
      ryear_in  = ryear_ff;
      rmonth_in = rmonth_ff;
      rday_in   = rday_ff;
      rstat_in  = rstat_ff;
      if (cmd.finish) begin
         if (bad_ff) begin
            ryear_in  = '0;
            rmonth_in = '0;
            rday_in   = '0;
            rstat_in  = dsd_pkg::StatusBadRange;
         end else if (stat.invalid) begin
            ryear_in  = '0;
            rmonth_in = '0;
            rday_in   = '0;
            rstat_in  = dsd_pkg::StatusBadDate;
         end else begin
            ryear_in  = year_ff;
            rmonth_in = month_ff;
            rday_in   = back_ff ? (day_ff - count_ff[dsd_pkg::DayW-1:0])
                                : (day_ff + count_ff[dsd_pkg::DayW-1:0]);
            rstat_in  = dsd_pkg::StatusOk;
         end
      end
   end

   always_ff @(posedge clock) begin
      back_ff   <= back_in;
      year_ff   <= year_in;
      yrem_ff   <= yrem_in;
      month_ff  <= month_in;
      day_ff    <= day_in;
      count_ff  <= count_in;
      bad_ff    <= bad_in;
      ryear_ff  <= ryear_in;
      rmonth_ff <= rmonth_in;
      rday_ff   <= rday_in;
      rstat_ff  <= rstat_in;
   end

   assign res_year   = ryear_ff;
   assign res_month  = rmonth_ff;
   assign res_day    = rday_ff;
   assign res_status = rstat_ff;

endmodule

`default_nettype wire

// ===== sv/date_shift_by_days_core.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Gregorian date shift: a request carries a start date, a day count and a
// direction (tuser 0 moves forward, 1 moves back), and one response returns
// the resulting date with a status (0 ok, 1 invalid start date, 2 result year
// outside 0..9999; the date fields are zero when the status is not ok).
// Requests are handled one at a time. After acceptance the year is first
// reduced modulo 400 by repeated subtraction, one subtraction per cycle (up to
// 24 subtractions for years up to 9999, 40 for the largest 14-bit value), then
// the walk advances one whole month per cycle. The walk then ends and the
// response register is written once the output is free; a new request is
// accepted as soon as that register is written, even while the previous
// response still waits to be taken.
module date_shift_by_days_core (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   // start_year[13:0], start_month[17:14], start_day[22:18], day_count[38:23], zero[39]
   input  wire logic [39:0] req_tdata,
   // action[0]
   input  wire logic [0:0]  req_tuser,
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   // result_year[13:0], result_month[17:14], result_day[22:18], status[24:23], zero[31:25]
   output logic [31:0]      rsp_tdata
);

   dsd_pkg::cmd_type                    cmd;
   dsd_pkg::stat_type                   stat;
   logic [dsd_pkg::YearW-1:0]           res_year;
   logic [dsd_pkg::MonthW-1:0]          res_month;
   logic [dsd_pkg::DayW-1:0]            res_day;
   logic [dsd_pkg::StatusW-1:0]         res_status;

   dsd_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .stat       (stat),
      .cmd        (cmd)
   );

   dsd_datapath u_datapath (
      .clock      (clock),
      .cmd        (cmd),
      .stat       (stat),
      .in_back    (req_tuser[0]),
      .in_year    (req_tdata[13:0]),
      .in_month   (req_tdata[17:14]),
      .in_day     (req_tdata[22:18]),
      .in_count   (req_tdata[38:23]),
      .res_year   (res_year),
      .res_month  (res_month),
      .res_day    (res_day),
      .res_status (res_status)
   );

   // Pack the response fields.
   assign rsp_tdata = {7'b0, res_status, res_day, res_month, res_year};

   // The status code is never the unused value.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (res_status <= dsd_pkg::StatusBadRange))
      else $error("response status holds an unused code");

   // A good response carries a month in 1..12, a nonzero day and a year up to 9999.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && res_status == dsd_pkg::StatusOk) |->
         (res_month != '0 && res_month <= dsd_pkg::MonthDec && res_day != '0 &&
          res_year <= dsd_pkg::YearMax))
      else $error("ok response with an impossible date");

   // A failed response carries zero date fields.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && res_status != dsd_pkg::StatusOk) |->
         (res_year == '0 && res_month == '0 && res_day == '0))
      else $error("failed response with nonzero date fields");

   // After a request is accepted, no further request is taken in the next cycle.
   assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> !req_tready)
      else $error("request taken while one is still in work");

endmodule

`default_nettype wire

// ===== sim/date_shift_by_days_core_tb.sv =====
`timescale 1ns / 1ps

module date_shift_by_days_core_tb;

   localparam logic ActForward    = 1'b0;
   localparam logic ActBackward   = 1'b1;
   localparam int   IdleLimit     = 20000;
   localparam int   SettleCycles  = 2400;
   localparam int   HoldOffCycles = 600;
   localparam int   MaxReports    = 10;
   localparam int   PhaseItems    = 62;

   typedef struct packed {
      logic [dsd_pkg::YearW-1:0]   year;
      logic [dsd_pkg::MonthW-1:0]  month;
      logic [dsd_pkg::DayW-1:0]    day;
      logic [dsd_pkg::StatusW-1:0] status;
   } shifted_date_type;

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [39:0] req_tdata  = '0;
   logic [0:0]  req_tuser  = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [31:0] rsp_tdata;

   shifted_date_type pending_dates[$];
   int mismatches     = 0;
   int send_idle_pct  = 0;
   int recv_stall_pct = 0;
   int hold_left      = 0;
   int quiet_cycles   = 0;

   date_shift_by_days_core dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   // Free-running clock, 10 ns period.
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Gregorian leap rule: every fourth year, except centuries not divisible by 400.
   function automatic bit is_leap(input int yr);
      return ((yr % 4 == 0) && (yr % 100 != 0)) || (yr % 400 == 0);
   endfunction

   function automatic int month_days(input int yr, input int mo);
      case (mo)
         2:            return is_leap(yr) ? 29 : 28;
         4, 6, 9, 11:  return 30;
         default:      return 31;
      endcase
   endfunction

   // Expected result of shifting a date by a number of days, one month at a time.
   function automatic shifted_date_type predict_shift(input logic act, input int yr,
                                                      input int mo, input int dy,
                                                      input int cnt);
      shifted_date_type res;
      bit out_of_range;
      res = '0;
      res.status = dsd_pkg::StatusOk;
      out_of_range = 1'b0;
      if (yr > int'(dsd_pkg::YearMax) || mo < 1 || mo > 12 || dy < 1 ||
          dy > month_days(yr, mo)) begin
         res.status = dsd_pkg::StatusBadDate;
         return res;
      end
      if (act == ActForward) begin
         while (cnt > month_days(yr, mo) - dy) begin
            cnt -= month_days(yr, mo) - dy + 1;
            dy = 1;
            mo++;
            if (mo > 12) begin
               mo = 1;
               yr++;
               if (yr > int'(dsd_pkg::YearMax)) begin
                  out_of_range = 1'b1;
                  break;
               end
            end
         end
         dy += cnt;
      end else begin
         while (cnt >= dy) begin
            cnt -= dy;
            if (mo <= 1) begin
               mo = 12;
               yr--;
               if (yr < 0) begin
                  out_of_range = 1'b1;
                  break;
               end
            end else begin
               mo--;
            end
            dy = month_days(yr, mo);
         end
         dy -= cnt;
      end
      if (out_of_range) begin
         res.status = dsd_pkg::StatusBadRange;
         return res;
      end
      res.year  = dsd_pkg::YearW'(yr);
      res.month = dsd_pkg::MonthW'(mo);
      res.day   = dsd_pkg::DayW'(dy);
      return res;
   endfunction

   // Offer one request, with a random gap first, and record its expected result.
   task automatic send_request(input logic act, input int yr, input int mo, input int dy,
                               input int cnt);
      int gap;
      @(negedge clock);
      gap = 0;
      while ($urandom_range(99) < send_idle_pct) gap++;
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= act;
      req_tdata  <= {1'b0, 16'(cnt), 5'(dy), 4'(mo), 14'(yr)};
      do @(posedge clock); while (!req_tready);
      pending_dates.push_back(predict_shift(act, yr, mo, dy, cnt));
   endtask

   // Drop the request valid and wait until every outstanding result is back.
   task automatic drain_requests();
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (pending_dates.size() != 0) @(posedge clock);
   endtask

   // Mostly well-formed dates with a skewed day count, the rest arbitrary field values.
   task automatic send_random_item();
      logic act;
      int   yr, mo, dy, cnt, pick;
      act  = 1'($urandom_range(1));
      pick = $urandom_range(99);
      if (pick < 15) begin
         yr = $urandom_range(16383);
         mo = $urandom_range(15);
         dy = $urandom_range(31);
      end else begin
         if (pick < 25)
            yr = $urandom_range(40);
         else if (pick < 35)
            yr = $urandom_range(int'(dsd_pkg::YearMax), int'(dsd_pkg::YearMax) - 40);
         else
            yr = $urandom_range(int'(dsd_pkg::YearMax));
         mo = $urandom_range(12, 1);
         dy = $urandom_range(month_days(yr, mo), 1);
      end
      pick = $urandom_range(99);
      if (pick < 5)
         cnt = 0;
      else if (pick < 60)
         cnt = $urandom_range(400);
      else if (pick < 92)
         cnt = $urandom_range(5000);
      else
         cnt = $urandom_range(65535);
      send_request(act, yr, mo, dy, cnt);
   endtask

   task automatic test_zero_count();
      send_request(ActForward, 2024, 5, 17, 0);
      send_request(ActBackward, 2024, 5, 17, 0);
      send_request(ActForward, 0, 1, 1, 0);
      send_request(ActBackward, 9999, 12, 31, 0);
   endtask

   task automatic test_field_extremes();
      send_request(ActForward, 0, 1, 1, 65535);
      send_request(ActBackward, 9999, 12, 31, 65535);
      send_request(ActForward, 5000, 8, 31, 65535);
      send_request(ActBackward, 5000, 7, 16, 1);
   endtask

   task automatic test_invalid_dates();
      send_request(ActForward, 16383, 1, 1, 5);
      send_request(ActBackward, 10000, 6, 15, 5);
      send_request(ActForward, 2020, 0, 10, 5);
      send_request(ActBackward, 2020, 13, 1, 5);
      send_request(ActForward, 2020, 15, 31, 5);
      send_request(ActForward, 2020, 3, 0, 5);
      send_request(ActBackward, 2021, 4, 31, 5);
      send_request(ActForward, 1900, 2, 29, 1);
   endtask

   task automatic test_leap_rules();
      send_request(ActForward, 2000, 2, 29, 1);
      send_request(ActForward, 1900, 2, 28, 1);
      send_request(ActForward, 2100, 2, 28, 1);
      send_request(ActBackward, 1600, 3, 1, 1);
      send_request(ActBackward, 2023, 3, 1, 1);
   endtask

   task automatic test_year_limits();
      send_request(ActForward, 9999, 12, 31, 1);
      send_request(ActBackward, 0, 1, 1, 1);
      send_request(ActForward, 9999, 12, 1, 30);
      send_request(ActBackward, 0, 1, 31, 31);
      send_request(ActForward, 9990, 1, 1, 65535);
   endtask

   task automatic test_random_phase(input int idle_pct, input int stall_pct);
      send_idle_pct  = idle_pct;
      recv_stall_pct = stall_pct;
      repeat (PhaseItems) send_random_item();
   endtask

   // The receiver holds off while requests keep coming, so the block fills and stalls.
   task automatic test_backpressure_fill();
      send_idle_pct  = 0;
      recv_stall_pct = 0;
      hold_left      = HoldOffCycles;
      repeat (6) send_request(1'($urandom_range(1)),
                              $urandom_range(int'(dsd_pkg::YearMax)), 3, 10,
                              $urandom_range(60));
   endtask

   // The sender pauses until every result is in, then resumes.
   task automatic test_drain_pause();
      send_idle_pct  = 0;
      recv_stall_pct = 15;
      repeat (4) send_random_item();
      drain_requests();
      repeat (4) send_random_item();
   endtask

   // Response ready: random stalls, or a long hold-off when one is requested.
   always @(negedge clock) begin
      if (hold_left > 0) begin
         hold_left  = hold_left - 1;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   // Compare each accepted response with the oldest expected date.
   always @(posedge clock) begin : check_responses
      shifted_date_type got, want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got.year   = rsp_tdata[13:0];
         got.month  = rsp_tdata[17:14];
         got.day    = rsp_tdata[22:18];
         got.status = rsp_tdata[24:23];
         if (pending_dates.size() == 0) begin
            mismatches++;
            if (mismatches <= MaxReports)
               $display("unexpected response: %0d-%0d-%0d status %0d",
                        got.year, got.month, got.day, got.status);
         end else begin
            want = pending_dates.pop_front();
            if (got.year != want.year || got.month != want.month ||
                got.day != want.day || got.status != want.status) begin
               mismatches++;
               if (mismatches <= MaxReports)
                  $display("mismatch: expected %0d-%0d-%0d status %0d, got %0d-%0d-%0d status %0d",
                           want.year, want.month, want.day, want.status,
                           got.year, got.month, got.day, got.status);
            end
         end
      end
   end

   // End the run if nothing moves on either side for too long.
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || reset)
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= IdleLimit) begin
         $display("FAIL date_shift_by_days_core");
         $finish;
      end
   end

   initial begin
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_zero_count();
      test_field_extremes();
      test_invalid_dates();
      test_leap_rules();
      test_year_limits();
      test_random_phase(0, 0);
      test_random_phase(74, 0);
      test_backpressure_fill();
      test_random_phase(0, 74);
      test_drain_pause();
      test_random_phase(15, 15);

      drain_requests();
      repeat (SettleCycles) @(posedge clock);
      if (mismatches == 0 && pending_dates.size() == 0)
         $display("PASS date_shift_by_days_core");
      else
         $display("FAIL date_shift_by_days_core");
      $finish;
   end

endmodule

// ===== filelist.f =====
sv/dsd_pkg.sv
sv/dsd_ctrl.sv
sv/dsd_datapath.sv
sv/date_shift_by_days_core.sv
sim/date_shift_by_days_core_tb.sv
